FILE: rtl/crc16_multi_variant_top_macros.svh
// ----------------------------------------------------------------------------
// CRC-16 multi-variant assertion macros
// Shared concurrent assertion forms, clocked on i_clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef CRC16_MULTI_VARIANT_TOP_MACROS_SVH
`define CRC16_MULTI_VARIANT_TOP_MACROS_SVH

// same-cycle implication
`define CRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/crc16_pkg.sv
// ----------------------------------------------------------------------------
// CRC-16 multi-variant package
// Mode codes, reflected polynomials, register map and the byte update function.
// ----------------------------------------------------------------------------
package crc16_pkg;

    localparam int MODE_W = 2;
    localparam int CRC_W  = 16;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [CRC_W-1:0]  t_crc;
    typedef logic [BYTE_W-1:0] t_byte;

    localparam t_mode MODE_KERMIT = 2'd0;
    localparam t_mode MODE_ARC    = 2'd1;
    localparam t_mode MODE_MODBUS = 2'd2;
    localparam t_mode MODE_USB    = 2'd3;

    // register index, taken from paddr[ADDR_W-1:2]
    localparam logic [ADDR_W-3:0] REG_CRC_MODE = 1'b0;

    // bit-reversed generators of 0x1021 and 0x8005
    localparam t_crc POLY_CCITT_REFL = 16'h8408;
    localparam t_crc POLY_IBM_REFL   = 16'hA001;
    localparam t_crc ALL_ONES        = 16'hFFFF;
    localparam t_crc ALL_ZEROS       = 16'h0000;

    function automatic t_crc mode_init(input t_mode m);
        t_crc v;
        case (m)
            MODE_MODBUS, MODE_USB: v = ALL_ONES;
            default:               v = ALL_ZEROS;
        endcase
        return v;
    endfunction

    function automatic t_crc mode_poly(input t_mode m);
        t_crc v;
        case (m)
            MODE_KERMIT: v = POLY_CCITT_REFL;
            default:     v = POLY_IBM_REFL;
        endcase
        return v;
    endfunction

    function automatic t_crc mode_xorout(input t_mode m);
        t_crc v;
        case (m)
            MODE_USB: v = ALL_ONES;
            default:  v = ALL_ZEROS;
        endcase
        return v;
    endfunction

    // one byte, shifted out LSB first
    function automatic t_crc crc_update(input t_crc crc, input t_byte b, input t_crc poly);
        t_crc c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ poly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/crc16_if.sv
// ----------------------------------------------------------------------------
// CRC-16 channel interfaces
// Valid/ready channels for message bytes and for finished CRC results.
// ----------------------------------------------------------------------------
interface crc16_item_if;
    logic                 valid;
    logic                 ready;
    crc16_pkg::t_byte     data_byte;
    logic                 last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crc16_result_if;
    logic                 valid;
    logic                 ready;
    crc16_pkg::t_crc      crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

FILE: rtl/crc16_multi_variant_top.sv
// ----------------------------------------------------------------------------
// CRC-16 multi-variant top level
// Reflected CRC-16 (KERMIT, ARC, MODBUS, USB) over a byte stream.
//
// Bytes enter on i_item, one per clock, and a message ends with the byte whose
// last_byte is set; that byte yields one crc_value on o_result via the input and
// result registers, and the running CRC reloads with the mode's initial value.
// Throughput is one byte per cycle while no last byte waits for the result slot,
// set by the single 8-bit unrolled update from input to running CRC register;
// the result register lets the next message in while a CRC waits to be taken.
// Select the variant in crc_mode (offset 0x0) only while the block is idle;
// a write there also restarts the running CRC.
// ----------------------------------------------------------------------------
module crc16_multi_variant_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    crc16_item_if.sink                     i_item,
    crc16_result_if.source                 o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [crc16_pkg::ADDR_W-1:0]   paddr,
    input  logic [crc16_pkg::DATA_W-1:0]   pwdata,
    output logic [crc16_pkg::DATA_W-1:0]   prdata,
    output logic                           pready
);

`include "crc16_multi_variant_top_macros.svh"

    crc16_pkg::t_mode r_mode;
    crc16_pkg::t_crc  r_crc;
    logic             r_in_valid;
    crc16_pkg::t_byte r_in_byte;
    logic             r_in_last;
    logic             r_out_valid;
    crc16_pkg::t_crc  r_out_crc;

    crc16_pkg::t_crc  n_crc;
    logic             w_in_ready;
    logic             w_in_accept;
    logic             w_adv;
    logic             w_mode_wr;
    logic             w_mode_sel;

    // configuration port
    assign pready     = 1'b1;
    assign w_mode_sel = (paddr[crc16_pkg::ADDR_W-1:2] == crc16_pkg::REG_CRC_MODE);
    assign w_mode_wr  = psel && penable && pwrite && w_mode_sel;
    assign prdata     = w_mode_sel
                        ? {{(crc16_pkg::DATA_W-crc16_pkg::MODE_W){1'b0}}, r_mode}
                        : '0;

    // a non-last byte never needs the result slot
    assign w_adv       = r_in_valid && (!r_in_last || !r_out_valid || o_result.ready);
    assign w_in_ready  = !r_in_valid || w_adv;
    assign w_in_accept = i_item.valid && w_in_ready;
    assign i_item.ready = w_in_ready;

    assign n_crc = crc16_pkg::crc_update(r_crc, r_in_byte, crc16_pkg::mode_poly(r_mode));

    assign o_result.valid     = r_out_valid;
    assign o_result.crc_value = r_out_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= crc16_pkg::MODE_KERMIT;
            r_crc       <= crc16_pkg::mode_init(crc16_pkg::MODE_KERMIT);
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end

            if (w_adv && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            // mode write restarts the running CRC
            if (w_mode_wr) begin
                r_mode <= pwdata[crc16_pkg::MODE_W-1:0];
                r_crc  <= crc16_pkg::mode_init(pwdata[crc16_pkg::MODE_W-1:0]);
            end else if (w_adv) begin
                r_crc <= r_in_last ? crc16_pkg::mode_init(r_mode) : n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_byte <= i_item.data_byte;
            r_in_last <= i_item.last_byte;
        end
        if (w_adv && r_in_last) begin
            r_out_crc <= n_crc ^ crc16_pkg::mode_xorout(r_mode);
        end
    end

    `CRC_ASSERT_NEXT(a_reload_after_last, w_adv && r_in_last,
        r_crc == crc16_pkg::mode_init(r_mode), "CRC not reloaded after last item")

    `CRC_ASSERT_NEXT(a_reload_after_mode, w_mode_wr,
        r_crc == crc16_pkg::mode_init(r_mode), "CRC not reloaded after mode write")

    `CRC_ASSERT_NOW(a_result_source, $rose(r_out_valid),
        $past(w_adv && r_in_last), "result appeared without a last item")

    `CRC_ASSERT_NEXT(a_input_held, r_in_valid && !w_adv,
        r_in_valid && $stable(r_in_byte) && $stable(r_in_last), "stalled item lost")

endmodule

FILE: verif/crc16_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 multi-variant checker
// Watches the byte, result and register channels, keeps its own running CRC
// per variant and compares every delivered crc_value with the oldest one due.
// ----------------------------------------------------------------------------
module crc16_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    crc16_item_if                          i_item,
    crc16_result_if                        i_result,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [crc16_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [crc16_pkg::DATA_W-1:0]   i_pwdata,
    input  logic                           i_pready,
    output int                             o_fail_count,
    output int                             o_pending
);

    // generators in normal bit order; the block shifts LSB first
    localparam crc16_pkg::t_crc GEN_CCITT = 16'h1021;
    localparam crc16_pkg::t_crc GEN_IBM   = 16'h8005;

    crc16_pkg::t_mode active_mode  = crc16_pkg::MODE_KERMIT;
    crc16_pkg::t_crc  running_crc  = '0;
    crc16_pkg::t_crc  due_crcs[$];
    int               fail_total   = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic crc16_pkg::t_crc variant_seed(input crc16_pkg::t_mode m);
        return (m == crc16_pkg::MODE_MODBUS || m == crc16_pkg::MODE_USB) ? 16'hFFFF : 16'h0000;
    endfunction

    function automatic crc16_pkg::t_crc variant_out_xor(input crc16_pkg::t_mode m);
        return (m == crc16_pkg::MODE_USB) ? 16'hFFFF : 16'h0000;
    endfunction

    function automatic crc16_pkg::t_crc variant_gen_refl(input crc16_pkg::t_mode m);
        crc16_pkg::t_crc g;
        crc16_pkg::t_crc r;
        g = (m == crc16_pkg::MODE_KERMIT) ? GEN_CCITT : GEN_IBM;
        r = {<<{g}};
        return r;
    endfunction

    // bit-serial form: feed each data bit against the register LSB
    function automatic crc16_pkg::t_crc crc_fold_byte(input crc16_pkg::t_crc c,
                                                      input crc16_pkg::t_byte b,
                                                      input crc16_pkg::t_crc gen);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ gen;
            end
        end
        return c;
    endfunction

    always @(posedge i_clk) begin
        crc16_pkg::t_crc want;
        if (!i_rst_n) begin
            active_mode = crc16_pkg::MODE_KERMIT;
            running_crc = variant_seed(crc16_pkg::MODE_KERMIT);
            due_crcs.delete();
        end else begin
            // a write to any other register index changes nothing
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[crc16_pkg::ADDR_W-1:2] == crc16_pkg::REG_CRC_MODE) begin
                active_mode = crc16_pkg::t_mode'(i_pwdata[crc16_pkg::MODE_W-1:0]);
                running_crc = variant_seed(active_mode);
            end
            if (i_result.valid && i_result.ready) begin
                if (due_crcs.size() == 0) begin
                    $display("%0t: crc_value %h delivered, expected none", $time,
                             i_result.crc_value);
                    fail_total++;
                end else begin
                    want = due_crcs.pop_front();
                    if (i_result.crc_value !== want) begin
                        $display("%0t: crc_value mismatch, expected %h, actual %h", $time,
                                 want, i_result.crc_value);
                        fail_total++;
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                running_crc = crc_fold_byte(running_crc, i_item.data_byte,
                                            variant_gen_refl(active_mode));
                if (i_item.last_byte) begin
                    due_crcs.push_back(running_crc ^ variant_out_xor(active_mode));
                    running_crc = variant_seed(active_mode);
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= due_crcs.size();
    end

endmodule

FILE: verif/tb_crc16_multi_variant_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 multi-variant testbench
// Streams directed and random messages through all four variants with
// random idle bursts on both channels and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_crc16_multi_variant_top;

    localparam logic [crc16_pkg::ADDR_W-1:0] ADDR_MODE   = {crc16_pkg::REG_CRC_MODE, 2'b00};
    localparam logic [crc16_pkg::ADDR_W-1:0] ADDR_UNUSED = 3'd4;
    localparam int DRAIN_CYCLES  = 4;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_BYTES   = 132;
    localparam int RUN_LIMIT_NS  = 5_000_000;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [crc16_pkg::ADDR_W-1:0]  paddr;
    logic [crc16_pkg::DATA_W-1:0]  pwdata;
    logic [crc16_pkg::DATA_W-1:0]  prdata;
    logic                          pready;
    int                            fail_count;
    int                            crcs_due;

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    int stall_left   = 0;

    crc16_item_if   item_ch ();
    crc16_result_if result_ch ();

    crc16_multi_variant_top u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    crc16_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (crcs_due)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: hold ready low in random bursts
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left       <= stall_left - 1;
            result_ch.ready  <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            stall_left       <= $urandom_range(0, 9);
            result_ch.ready  <= 1'b0;
        end else begin
            result_ch.ready  <= 1'b1;
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic apb_write(input logic [crc16_pkg::ADDR_W-1:0] addr,
                             input logic [crc16_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_mode(input crc16_pkg::t_mode m);
        logic [31:0] rnd;
        rnd = $urandom();
        apb_write(ADDR_MODE, {rnd[31:crc16_pkg::MODE_W], m});
    endtask

    // leave valid high across back-to-back items; drop it only for a gap
    task automatic send_byte(input crc16_pkg::t_byte b, input logic is_last);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.data_byte <= b;
        item_ch.last_byte <= is_last;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (crcs_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        int               count;
        int               len;
        int               tail;
        crc16_pkg::t_mode mode;
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        item_ch.valid       = 1'b0;
        item_ch.data_byte   = '0;
        item_ch.last_byte   = 1'b0;
        result_ch.ready     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // kermit out of reset: single-byte messages at the byte extremes
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // partial message abandoned by a mode write
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        wait_drained();
        apb_write(ADDR_MODE, {30'h0, crc16_pkg::MODE_ARC});
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b1);
        // write to an unused index mid-message must not disturb the running CRC
        send_byte(8'h80, 1'b0);
        wait_drained();
        apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
        send_byte(8'h7F, 1'b1);
        wait_drained();
        apb_write(ADDR_MODE, {30'h0, crc16_pkg::MODE_MODBUS});
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_drained();
        apb_write(ADDR_MODE, {30'h3FFF_FFFF, crc16_pkg::MODE_USB});
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // quiet stretches in some phases, none at all in the last one
            src_idle_en  = (ph != NUM_PHASES - 1) && (ph % 4 != 1);
            sink_idle_en = (ph != NUM_PHASES - 1) && (ph % 4 != 2);
            mode = (ph < 4) ? crc16_pkg::t_mode'(3 - ph)
                            : crc16_pkg::t_mode'($urandom_range(0, 3));
            set_mode(mode);
            if ($urandom_range(0, 2) == 0) begin
                apb_write(ADDR_UNUSED, $urandom());
            end
            count = 0;
            while (count < PHASE_BYTES) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48)
                                                  : $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    send_byte(crc16_pkg::t_byte'($urandom_range(0, 255)), k == len - 1);
                end
                count += len;
                if ($urandom_range(0, 19) == 0) begin
                    wait_drained();
                end
            end
            // sometimes leave a message open for the next mode write to drop
            if ($urandom_range(0, 1) == 0) begin
                tail = $urandom_range(1, 3);
                repeat (tail) send_byte(crc16_pkg::t_byte'($urandom_range(0, 255)), 1'b0);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && crcs_due == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
